>>> design/kdeq_pkg.sv
package kdeq_pkg;

    // Defaults for the top-level parameters
    localparam int NUM_KEYS_DEF    = 8;
    localparam int QUEUE_DEPTH_DEF = 16;

    // Fixed field widths
    localparam int LEVEL_W     = 8;   // raw key levels carried per tick
    localparam int LEVEL_IDX_W = 3;   // bits to index one level
    localparam int KEY_CODE_W  = 3;   // key index carried in an event
    localparam int STABLE_W    = 8;   // debounce threshold / counter width

    localparam logic [STABLE_W-1:0] STABLE_RESET = 8'd5;
    localparam logic [STABLE_W-1:0] CNT_MAX      = 8'hFF;

    // Request kinds
    typedef enum logic {
        CMD_SCAN = 1'b0,
        CMD_POP  = 1'b1
    } t_cmd;

    // One request as handed from front to back
    typedef struct packed {
        t_cmd               cmd;
        logic [LEVEL_W-1:0] levels;
    } t_req;

    // One queued event, as stored in the ring
    typedef struct packed {
        logic                  release_evt;
        logic [KEY_CODE_W-1:0] key;
    } t_evt;

    localparam int EVT_W = $bits(t_evt);

    // One result handed to the output channel
    typedef struct packed {
        logic                  evt_valid;
        logic                  release_evt;
        logic [KEY_CODE_W-1:0] key;
    } t_result;

endpackage

>>> design/key_debounce_event_queue.sv
// Key debounce with press/release event queue.
//
// Input stream (s_axis): one request per transfer. tuser[0] selects the kind:
//   0 = scan tick, tdata[7:0] holds the raw key levels (1 = released);
//   1 = pop, tdata is ignored. A scan gives no response; a pop gives exactly
//   one response on m_axis.
// Output stream (m_axis): tdata[2:0] = key index, tuser[0] = event valid
//   (0 = queue was empty), tuser[1] = release (0 = press).
// Config: i_cfg_wr_en/i_cfg_wr_data write the debounce threshold in ticks
//   (0 acts as 1). Write only while the block is idle.
// Timing: a scan is dispatched from idle, then the scanner takes one key per
//   cycle through the shared counter update. A pop is read from the event
//   ring, then passes the pop state into the output register; a pop on an
//   empty queue goes straight to the output register. The scanner takes no
//   new request until it is back in idle from the last scan or pop.
// A two-entry request queue takes new requests while a response waits on a
//   stalled m_axis; scans keep running under that stall, a pop waits for the
//   output register to empty.
// Reset: all keys accepted as pressed, counters cleared, event ring empty,
//   threshold back to 5. Events found while the ring is full are dropped,
//   so it holds QUEUE_DEPTH - 1 events at most.
module key_debounce_event_queue #(
    parameter int NUM_KEYS    = kdeq_pkg::NUM_KEYS_DEF,
    parameter int QUEUE_DEPTH = kdeq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] key_levels
    input  logic [0:0]                    s_axis_tuser,   // [0] cmd
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,   // [2:0] event_key, rest zero
    output logic [1:0]                    m_axis_tuser,   // [0] event_valid, [1] event_release
    input  logic                          i_cfg_wr_en,
    input  logic [kdeq_pkg::STABLE_W-1:0] i_cfg_wr_data
);

    import kdeq_pkg::*;

    logic [STABLE_W-1:0] r_stable_ticks;
    t_req                w_in_req;
    t_req                w_req;
    logic                w_req_valid, w_req_ready;
    t_result             w_res;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable_ticks <= STABLE_RESET;
        end else if (i_cfg_wr_en) begin
            r_stable_ticks <= i_cfg_wr_data;
        end
    end

    always_comb begin
        w_in_req.cmd    = t_cmd'(s_axis_tuser[0]);
        w_in_req.levels = s_axis_tdata;
    end

    // front: accepts and classifies requests into a short queue
    kdeq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_req       (w_in_req),
        .o_req_valid (w_req_valid),
        .i_req_ready (w_req_ready),
        .o_req       (w_req)
    );

    // back: key scanner, event ring and output register
    kdeq_back #(
        .NUM_KEYS    (NUM_KEYS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_stable_ticks (r_stable_ticks),
        .i_req_valid    (w_req_valid),
        .o_req_ready    (w_req_ready),
        .i_req          (w_req),
        .o_res_valid    (m_axis_tvalid),
        .i_res_ready    (m_axis_tready),
        .o_res          (w_res)
    );

    assign m_axis_tdata = {{(8 - KEY_CODE_W){1'b0}}, w_res.key};
    assign m_axis_tuser = {w_res.release_evt, w_res.evt_valid};

endmodule

>>> design/kdeq_ram.sv
module kdeq_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/kdeq_front.sv
module kdeq_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  kdeq_pkg::t_req i_req,
    output logic          o_req_valid,
    input  logic          i_req_ready,
    output kdeq_pkg::t_req o_req
);

    import kdeq_pkg::*;

    // two-entry request queue between the port and the back end
    t_req       r_slot [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       w_push, w_pop;
    t_req       w_req;

    // classify: only the lowest bit selects the kind, levels pass as is
    always_comb begin
        w_req        = i_req;
        w_req.cmd    = (i_req.cmd == CMD_POP) ? CMD_POP : CMD_SCAN;
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_slot[r_rp];

    assign w_push = i_valid && o_ready;
    assign w_pop  = o_req_valid && i_req_ready;

    always_comb begin
        n_wp  = w_push ? ~r_wp : r_wp;
        n_rp  = w_pop  ? ~r_rp : r_rp;
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (w_push) begin
            r_slot[r_wp] <= w_req;
        end
    end

endmodule

>>> design/kdeq_back.sv
module kdeq_back #(
    parameter int NUM_KEYS    = kdeq_pkg::NUM_KEYS_DEF,
    parameter int QUEUE_DEPTH = kdeq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [kdeq_pkg::STABLE_W-1:0]    i_stable_ticks,
    input  logic                             i_req_valid,
    output logic                             o_req_ready,
    input  kdeq_pkg::t_req                   i_req,
    output logic                             o_res_valid,
    input  logic                             i_res_ready,
    output kdeq_pkg::t_result                o_res
);

    import kdeq_pkg::*;

    localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int EXT_W = 6;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_POP  = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [KEY_W-1:0]    r_idx, n_idx;
    logic [LEVEL_W-1:0]  r_levels, n_levels;
    logic [PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [STABLE_W-1:0] r_cnt [NUM_KEYS];
    logic [NUM_KEYS-1:0] r_acc;
    logic                r_out_valid, n_out_valid;
    t_result             r_out, n_out;

    logic [STABLE_W-1:0] w_thr;
    logic [STABLE_W-1:0] w_cnt_cur, w_cnt_inc, n_cnt_sel;
    logic                w_acc_cur, n_acc_sel;
    logic [EXT_W-1:0]    w_idx_ext;
    logic                w_raw, w_hit;
    logic [PTR_W-1:0]    w_wr_next, w_rd_next;
    logic                w_full, w_empty;
    logic                w_push;
    t_evt                w_push_evt;
    logic                w_rd_en;
    t_evt                w_rd_evt;
    logic                w_last_key;

    // per-key step for the key under scan
    assign w_thr      = (i_stable_ticks == '0) ? STABLE_W'(1) : i_stable_ticks;
    assign w_idx_ext  = EXT_W'(r_idx);
    assign w_raw      = (w_idx_ext < EXT_W'(LEVEL_W)) ?
                        r_levels[w_idx_ext[LEVEL_IDX_W-1:0]] : 1'b1;
    assign w_cnt_cur  = r_cnt[r_idx];
    assign w_acc_cur  = r_acc[r_idx];
    assign w_cnt_inc  = (w_raw != w_acc_cur) ?
                        ((w_cnt_cur == CNT_MAX) ? w_cnt_cur : w_cnt_cur + 1'b1) : '0;
    assign w_hit      = (w_cnt_inc >= w_thr);
    assign n_cnt_sel  = w_hit ? '0 : w_cnt_inc;
    assign n_acc_sel  = w_hit ? ~w_acc_cur : w_acc_cur;
    assign w_last_key = (r_idx == KEY_W'(NUM_KEYS - 1));

    // ring pointers
    assign w_wr_next = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign w_rd_next = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    assign w_full    = (w_wr_next == r_rd_ptr);
    assign w_empty   = (r_rd_ptr == r_wr_ptr);

    assign w_push                 = (r_state == S_SCAN) && w_hit && !w_full;
    assign w_push_evt.release_evt = n_acc_sel;
    assign w_push_evt.key         = KEY_CODE_W'(r_idx);

    // take a request when idle; a pop also needs the output register free
    assign o_req_ready = (r_state == S_IDLE) &&
                         ((i_req.cmd == CMD_SCAN) || !r_out_valid);

    assign w_rd_en = (r_state == S_IDLE) && i_req_valid && o_req_ready &&
                     (i_req.cmd == CMD_POP) && !w_empty;

    kdeq_ram #(
        .WIDTH (EVT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_push),
        .i_wr_addr (r_wr_ptr),
        .i_wr_data (w_push_evt),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (w_rd_evt)
    );

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_levels    = r_levels;
        n_rd_ptr    = r_rd_ptr;
        n_wr_ptr    = w_push ? w_wr_next : r_wr_ptr;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && i_res_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid && o_req_ready) begin
                    if (i_req.cmd == CMD_SCAN) begin
                        n_levels = i_req.levels;
                        n_idx    = '0;
                        n_state  = S_SCAN;
                    end else if (w_empty) begin
                        n_out_valid = 1'b1;
                        n_out       = '0;
                    end else begin
                        n_rd_ptr = w_rd_next;
                        n_state  = S_POP;
                    end
                end
            end
            S_SCAN: begin
                n_idx = r_idx + 1'b1;
                if (w_last_key) begin
                    n_state = S_IDLE;
                end
            end
            S_POP: begin
                // output register is known free here
                n_out_valid       = 1'b1;
                n_out.evt_valid   = 1'b1;
                n_out.release_evt = w_rd_evt.release_evt;
                n_out.key         = w_rd_evt.key;
                n_state           = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_out_valid <= 1'b0;
            r_acc       <= '0;
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_rd_ptr    <= n_rd_ptr;
            r_wr_ptr    <= n_wr_ptr;
            r_out_valid <= n_out_valid;
            if (r_state == S_SCAN) begin
                r_cnt[r_idx] <= n_cnt_sel;
                r_acc[r_idx] <= n_acc_sel;
            end
        end
        r_levels <= n_levels;
        r_out    <= n_out;
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule
